### hw/rtl/assert_macros.svh
// Assertion macros used by the orthonormaliser sequencer, gso_ctrl.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hw/rtl/gso_pkg.sv
// Shared types and constants for the Gram-Schmidt block.
// No dependencies.
`timescale 1ns / 1ps
package gso_pkg;
	localparam logic [1:0] REG_DIMENSION = 2'd0;
	localparam logic [1:0] REG_VECTOR_COUNT = 2'd1;
	localparam logic [1:0] REG_NORMALIZE = 2'd2;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_PJ_CLR,
		ST_PJ_DOT,
		ST_PJ_CHK,
		ST_PJ_START,
		ST_PJ_DIV,
		ST_PJ_UPD,
		ST_PJ_FLUSH,
		ST_PJ_NEXT,
		ST_NM_CLR,
		ST_NM_DOT,
		ST_NM_CHK,
		ST_NM_SQRT,
		ST_NM_SWAIT,
		ST_NM_RD,
		ST_NM_DIVS,
		ST_NM_DWAIT,
		ST_NM_WR,
		ST_NM_NEXT,
		ST_OUT_PRE,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_CLR,
		OP_ACC,
		OP_PDIV,
		OP_SQRT,
		OP_UPD,
		OP_NDIV,
		OP_NWR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] ra_vec;
		logic [3:0] rb_vec;
		logic [3:0] comp;
		logic       wr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic den_zero;
		logic len_zero;
	} dp_sts_t;
endpackage

### hw/rtl/gso_ram.sv
// Generic single write port, dual registered read port RAM.
// No dependencies.
`timescale 1ns / 1ps
module gso_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

### hw/rtl/gso_datapath.sv
// Datapath: vector RAM, dot accumulators, serial divider and square root.
// Depends on gso_pkg and gso_ram.
`timescale 1ns / 1ps
module gso_datapath #(
	parameter int MAX_DIM = 8,
	parameter int MAX_VECTORS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gso_pkg::dp_cmd_t           cmd,
	input  logic [3:0]                 wr_vec,
	input  logic [3:0]                 wr_comp,
	input  logic [31:0]                wr_data,
	output gso_pkg::dp_sts_t           sts,
	output logic [31:0]                rd_data
);
	import gso_pkg::*;
	localparam int DEPTH = MAX_DIM * MAX_VECTORS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [AW-1:0] waddr, raddr_a, raddr_b, waddr_s1;
	logic [31:0] ra, rb, wdata;
	logic we;
	logic acc_s1, upd_s1;
	logic signed [63:0] acc_aa_q, acc_ab_q;
	logic signed [63:0] prod_aa, prod_ab, upd_term;
	logic [31:0] mul_b, div_res, upd_val;
	logic signed [64:0] diff;
	logic signed [63:0] num_s;
	logic [63:0] num_mag, den_in;
	logic [63:0] rem_q, dvs_q, rem_sh;
	logic [64:0] rem_try;
	logic [31:0] quo_q, dnd_q;
	logic neg_q, sat_q;
	logic [63:0] sq_x_q, sq_r_q, sq_bit_q, sq_try, len;
	logic big_q, sqrt_mode_q, sq_small;
	logic [5:0] cnt_q;
	logic busy_q;

	function automatic logic [AW-1:0] addr_of(input logic [3:0] v, input logic [3:0] c);
		logic [31:0] a;
		a = 32'(v) * 32'(MAX_DIM) + 32'(c);
		return a[AW-1:0];
	endfunction

	assign raddr_a = addr_of(cmd.ra_vec, cmd.comp);
	assign raddr_b = addr_of(cmd.rb_vec, cmd.comp);

	gso_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(ra), .rdata_b(rb)
	);

	assign mul_b = upd_s1 ? div_res : ra;
	assign prod_aa = 64'($signed(ra)) * 64'($signed(mul_b));
	assign prod_ab = 64'($signed(ra)) * 64'($signed(rb));
	assign upd_term = prod_aa >>> 16;
	assign diff = 65'($signed(rb)) - 65'(upd_term);
	assign upd_val = (diff > 65'sd2147483647) ? 32'h7FFFFFFF :
		(diff < -65'sd2147483648) ? 32'h80000000 : diff[31:0];

	assign num_s = (cmd.op == OP_NDIV) ? 64'($signed(rb)) : acc_ab_q;
	assign num_mag = num_s[63] ? $unsigned(-num_s) : $unsigned(num_s);
	assign den_in = (cmd.op == OP_NDIV) ? len : $unsigned(acc_aa_q);
	assign rem_sh = {rem_q[62:0], dnd_q[31]};
	assign rem_try = {1'b0, rem_sh} - {1'b0, dvs_q};
	assign div_res = sat_q ? (neg_q ? 32'h80000000 : 32'h7FFFFFFF) :
		neg_q ? (quo_q[31] ? 32'h80000000 : 32'(32'd0 - quo_q)) :
		(quo_q[31] ? 32'h7FFFFFFF : quo_q);

	assign sq_small = $unsigned(acc_aa_q) < (64'd1 << 55);
	assign sq_try = sq_r_q + sq_bit_q;
	assign len = big_q ? {sq_r_q[59:0], 4'd0} : sq_r_q;

	always_comb begin
		we = 1'b0;
		waddr = addr_of(wr_vec, wr_comp);
		wdata = wr_data;
		if (cmd.wr_en) begin
			we = 1'b1;
		end else if (upd_s1) begin
			we = 1'b1;
			waddr = waddr_s1;
			wdata = upd_val;
		end else if (cmd.op == OP_NWR) begin
			we = 1'b1;
			waddr = raddr_b;
			wdata = div_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			sqrt_mode_q <= 1'b0;
			acc_s1 <= 1'b0;
			upd_s1 <= 1'b0;
			waddr_s1 <= '0;
		end else begin
			acc_s1 <= (cmd.op == OP_ACC);
			upd_s1 <= (cmd.op == OP_UPD);
			waddr_s1 <= raddr_b;
			if (!busy_q && (cmd.op inside {OP_PDIV, OP_NDIV, OP_SQRT})) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
				sqrt_mode_q <= (cmd.op == OP_SQRT);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLR) begin
			acc_aa_q <= '0;
			acc_ab_q <= '0;
		end else if (acc_s1) begin
			acc_aa_q <= acc_aa_q + (prod_aa >>> 8);
			acc_ab_q <= acc_ab_q + (prod_ab >>> 8);
		end
		if (!busy_q && (cmd.op inside {OP_PDIV, OP_NDIV})) begin
			rem_q <= num_mag >> 16;
			dnd_q <= {num_mag[15:0], 16'd0};
			dvs_q <= den_in;
			neg_q <= num_s[63];
			sat_q <= (num_mag >> 16) >= den_in;
			quo_q <= '0;
		end else if (busy_q && !sqrt_mode_q) begin
			if (!rem_try[64]) begin
				rem_q <= rem_try[63:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
			dnd_q <= {dnd_q[30:0], 1'b0};
		end
		if (!busy_q && cmd.op == OP_SQRT) begin
			sq_x_q <= sq_small ? ($unsigned(acc_aa_q) << 8) : $unsigned(acc_aa_q);
			sq_r_q <= '0;
			sq_bit_q <= 64'd1 << 62;
			big_q <= !sq_small;
		end else if (busy_q && sqrt_mode_q) begin
			if (sq_x_q >= sq_try) begin
				sq_x_q <= sq_x_q - sq_try;
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	assign sts.busy = busy_q;
	assign sts.den_zero = (acc_aa_q == 0);
	assign sts.len_zero = (len == 0);
	assign rd_data = rb;
endmodule

### hw/rtl/gso_ctrl.sv
// Sequencer for load, projection, normalisation and result streaming.
// Depends on gso_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gso_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [3:0]                 dim,
	input  logic [3:0]                 cnt,
	input  logic                       norm_en,
	input  logic                       restart,
	input  logic                       in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [3:0]                 vec,
	output logic [3:0]                 comp,
	output logic                       last,
	output gso_pkg::dp_cmd_t           cmd,
	input  gso_pkg::dp_sts_t           sts
);
	import gso_pkg::*;
	state_t state_q, state_d;
	logic [3:0] i_q, j_q, c_q;
	logic [3:0] i_d, j_d, c_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			i_q <= '0;
			j_q <= '0;
			c_q <= '0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			c_q <= c_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		c_d = c_q;
		cmd = '{op: OP_IDLE, ra_vec: j_q, rb_vec: i_q, comp: c_q, wr_en: 1'b0};
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
		ST_LOAD: begin
			in_stall = restart;
			if (restart) begin
				i_d = '0;
				c_d = '0;
			end else if (in_valid) begin
				cmd.wr_en = 1'b1;
				c_d = c_q + 4'd1;
				if (c_q == dim - 4'd1) begin
					c_d = '0;
					i_d = i_q + 4'd1;
					if (i_q == cnt - 4'd1) begin
						j_d = '0;
						if (cnt == 4'd1) begin
							i_d = '0;
							state_d = norm_en ? ST_NM_CLR : ST_OUT_PRE;
						end else begin
							i_d = 4'd1;
							state_d = ST_PJ_CLR;
						end
					end
				end
			end
		end
		ST_PJ_CLR: begin
			cmd.op = OP_CLR;
			c_d = '0;
			state_d = ST_PJ_DOT;
		end
		ST_PJ_DOT: begin
			cmd.op = OP_ACC;
			if (c_q == dim - 4'd1) state_d = ST_PJ_CHK;
			else c_d = c_q + 4'd1;
		end
		ST_PJ_CHK: begin
			state_d = ST_PJ_START;
		end
		ST_PJ_START: begin
			if (sts.den_zero) begin
				state_d = ST_PJ_NEXT;
			end else begin
				cmd.op = OP_PDIV;
				state_d = ST_PJ_DIV;
			end
		end
		ST_PJ_DIV: begin
			if (!sts.busy) begin
				c_d = '0;
				state_d = ST_PJ_UPD;
			end
		end
		ST_PJ_UPD: begin
			cmd.op = OP_UPD;
			if (c_q == dim - 4'd1) state_d = ST_PJ_FLUSH;
			else c_d = c_q + 4'd1;
		end
		ST_PJ_FLUSH: begin
			state_d = ST_PJ_NEXT;
		end
		ST_PJ_NEXT: begin
			if (j_q == i_q - 4'd1) begin
				j_d = '0;
				if (i_q == cnt - 4'd1) begin
					i_d = '0;
					state_d = norm_en ? ST_NM_CLR : ST_OUT_PRE;
				end else begin
					i_d = i_q + 4'd1;
					state_d = ST_PJ_CLR;
				end
			end else begin
				j_d = j_q + 4'd1;
				state_d = ST_PJ_CLR;
			end
		end
		ST_NM_CLR: begin
			cmd.op = OP_CLR;
			c_d = '0;
			state_d = ST_NM_DOT;
		end
		ST_NM_DOT: begin
			cmd.op = OP_ACC;
			cmd.ra_vec = i_q;
			if (c_q == dim - 4'd1) state_d = ST_NM_CHK;
			else c_d = c_q + 4'd1;
		end
		ST_NM_CHK: begin
			state_d = ST_NM_SQRT;
		end
		ST_NM_SQRT: begin
			cmd.op = OP_SQRT;
			state_d = ST_NM_SWAIT;
		end
		ST_NM_SWAIT: begin
			if (!sts.busy) begin
				c_d = '0;
				state_d = sts.len_zero ? ST_NM_NEXT : ST_NM_RD;
			end
		end
		ST_NM_RD: begin
			state_d = ST_NM_DIVS;
		end
		ST_NM_DIVS: begin
			cmd.op = OP_NDIV;
			state_d = ST_NM_DWAIT;
		end
		ST_NM_DWAIT: begin
			if (!sts.busy) state_d = ST_NM_WR;
		end
		ST_NM_WR: begin
			cmd.op = OP_NWR;
			if (c_q == dim - 4'd1) begin
				state_d = ST_NM_NEXT;
			end else begin
				c_d = c_q + 4'd1;
				state_d = ST_NM_RD;
			end
		end
		ST_NM_NEXT: begin
			if (i_q == cnt - 4'd1) begin
				i_d = '0;
				state_d = ST_OUT_PRE;
			end else begin
				i_d = i_q + 4'd1;
				state_d = ST_NM_CLR;
			end
		end
		ST_OUT_PRE: begin
			i_d = '0;
			c_d = '0;
			state_d = ST_OUT;
			cmd.rb_vec = i_d;
			cmd.comp = c_d;
		end
		ST_OUT: begin
			out_valid = 1'b1;
			if (!out_stall) begin
				c_d = c_q + 4'd1;
				if (c_q == dim - 4'd1) begin
					c_d = '0;
					i_d = i_q + 4'd1;
					if (i_q == cnt - 4'd1) begin
						i_d = '0;
						state_d = ST_LOAD;
					end
				end
			end
			cmd.rb_vec = i_d;
			cmd.comp = c_d;
		end
		default: begin
			state_d = ST_LOAD;
		end
		endcase
	end

	assign vec = i_q;
	assign comp = c_q;
	assign last = (i_q == cnt - 4'd1) && (c_q == dim - 4'd1);

	`CHK_IMPL(a_out_ld, out_valid, state_q != ST_LOAD, "output during load")
	`CHK_IMPL(a_in_ld, !in_stall, state_q == ST_LOAD, "input taken outside load")
	`CHK_NEXT(a_wrap, state_q == ST_OUT && last && !out_stall, state_q == ST_LOAD, "no wrap")
endmodule

### hw/rtl/gram_schmidt_orthonormalizer_top.sv
// Modified Gram-Schmidt, signed Q16.16; loads one component beat per cycle, vector-major.
// After the last beat, each earlier vector is projected out of each later one (skipped when the
// earlier vector is zero), then, normalising, each vector is divided by its length (skipped at
// zero length). Results then leave one beat per cycle while out_stall is low.
// One job at a time; input stalls until the last result is taken.
// Reset (asynchronous, active low) sets dimension 8, count 8, normalise on, load position 0.
`timescale 1ns / 1ps
module gram_schmidt_orthonormalizer_top #(
	parameter int MAX_DIM = 8,
	parameter int MAX_VECTORS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] component_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic [2:0]  vector_index,
	output logic [2:0]  component_index,
	output logic        last_result
);
	import gso_pkg::*;
	logic [3:0] dim_q, cnt_q, dim_e, cnt_e, vec, comp;
	logic norm_q, restart;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 4'd8;
			cnt_q <= 4'd8;
			norm_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
			REG_DIMENSION: dim_q <= cfg_data;
			REG_VECTOR_COUNT: cnt_q <= cfg_data;
			REG_NORMALIZE: norm_q <= cfg_data[0];
			default: ;
			endcase
		end
	end

	assign dim_e = (dim_q == 0) ? 4'd1 : (32'(dim_q) > MAX_DIM) ? 4'(MAX_DIM) : dim_q;
	assign cnt_e = (cnt_q == 0) ? 4'd1 : (32'(cnt_q) > MAX_VECTORS) ? 4'(MAX_VECTORS) : cnt_q;
	assign restart = cfg_we && (cfg_index == REG_DIMENSION || cfg_index == REG_VECTOR_COUNT);

	gso_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .dim(dim_e), .cnt(cnt_e), .norm_en(norm_q),
		.restart(restart), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .vec(vec), .comp(comp),
		.last(last_result), .cmd(cmd), .sts(sts)
	);

	gso_datapath #(.MAX_DIM(MAX_DIM), .MAX_VECTORS(MAX_VECTORS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .wr_vec(vec), .wr_comp(comp),
		.wr_data(component_value), .sts(sts), .rd_data(result_value)
	);

	assign vector_index = vec[2:0];
	assign component_index = comp[2:0];
endmodule

### bench/tb_gram_schmidt_orthonormalizer_top.sv
// Self-checking bench for the Gram-Schmidt orthonormaliser top level.
// Drives vector jobs under random idling, predicts results in Q16.16; uses gso_pkg.
`timescale 1ns / 1ps
module tb_gram_schmidt_orthonormalizer_top;
	import gso_pkg::*;

	localparam int MAXD = 8;
	localparam int MAXN = 8;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [31:0] value;
		logic [2:0]  vec;
		logic [2:0]  comp;
		logic        last;
	} result_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_DIMENSION;
	logic [3:0]  cfg_data = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] component_value = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_value;
	logic [2:0]  vector_index;
	logic [2:0]  component_index;
	logic        last_result;

	logic [31:0]  component_fifo[$];
	result_beat_t expected_results[$];
	int           vec_mem[MAXN][MAXD];
	int unsigned  fill_pos;
	logic [3:0]   dim_reg, count_reg;
	logic         norm_reg;
	bit           failed = 1'b0;
	bit           calm = 1'b0;
	longint       cyc = 0;
	int           items_sent = 0;

	gram_schmidt_orthonormalizer_top #(.MAX_DIM(MAXD), .MAX_VECTORS(MAXN)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .component_value(component_value),
		.out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
		.vector_index(vector_index), .component_index(component_index),
		.last_result(last_result)
	);

	always #6 clk = ~clk;

	function automatic int unsigned eff_dim();
		if (dim_reg == 0) return 1;
		return (dim_reg > MAXD) ? MAXD : dim_reg;
	endfunction

	function automatic int unsigned eff_count();
		if (count_reg == 0) return 1;
		return (count_reg > MAXN) ? MAXN : count_reg;
	endfunction

	function automatic longint dot_q24(int a, int b, int unsigned d);
		longint s;
		s = 0;
		for (int unsigned c = 0; c < d; c++)
			s += (longint'(vec_mem[a][c]) * longint'(vec_mem[b][c])) >>> 8;
		return s;
	endfunction

	function automatic int sat32(longint x);
		if (x > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (x < -64'sh80000000) return 32'h80000000;
		return int'(x);
	endfunction

	function automatic int div_q16(longint num, longint den);
		logic                neg;
		longint unsigned     mag_in;
		logic [127:0]        quo;
		neg = num < 0;
		mag_in = neg ? longint'(-num) : num;
		if (mag_in / longint'(den) >= 65536) return neg ? 32'h80000000 : 32'h7FFFFFFF;
		quo = ({64'd0, mag_in} << 16) / {64'd0, den};
		if (neg) begin
			if (quo >= 128'h80000000) return 32'h80000000;
			return int'(-longint'(quo[63:0]));
		end
		if (quo > 128'h7FFFFFFF) return 32'h7FFFFFFF;
		return int'(quo[31:0]);
	endfunction

	function automatic longint unsigned isqrt64(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	task automatic orthonormalise(int unsigned d, int unsigned n);
		longint den, s;
		longint unsigned len;
		int f;
		for (int unsigned i = 1; i < n; i++)
			for (int unsigned j = 0; j < i; j++) begin
				den = dot_q24(j, j, d);
				if (den != 0) begin
					f = div_q16(dot_q24(j, i, d), den);
					for (int unsigned c = 0; c < d; c++)
						vec_mem[i][c] = sat32(longint'(vec_mem[i][c])
							- ((longint'(f) * longint'(vec_mem[j][c])) >>> 16));
				end
			end
		if (norm_reg)
			for (int unsigned i = 0; i < n; i++) begin
				s = dot_q24(i, i, d);
				if (s < (64'sd1 <<< 55)) len = isqrt64(longint'(s) << 8);
				else len = isqrt64(s) << 4;
				if (len != 0)
					for (int unsigned c = 0; c < d; c++)
						vec_mem[i][c] = div_q16(vec_mem[i][c], len);
			end
	endtask

	task automatic predict_component(logic [31:0] val);
		int unsigned d, n, total;
		result_beat_t r;
		d = eff_dim();
		n = eff_count();
		total = d * n;
		if (fill_pos >= total) fill_pos = 0;
		vec_mem[fill_pos / d][fill_pos % d] = val;
		fill_pos++;
		if (fill_pos >= total) begin
			fill_pos = 0;
			orthonormalise(d, n);
			for (int unsigned v = 0; v < n; v++)
				for (int unsigned c = 0; c < d; c++) begin
					r.value = vec_mem[v][c];
					r.vec = v[2:0];
					r.comp = c[2:0];
					r.last = (v == n - 1) && (c == d - 1);
					expected_results.push_back(r);
				end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) predict_component(component_value);
			if (component_fifo.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
				in_valid <= 1'b1;
				component_value <= component_fifo.pop_front();
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_beat_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h v%0d c%0d l%0d", $time,
						result_value, vector_index, component_index, last_result);
					failed = 1'b1;
				end else begin
					e = expected_results.pop_front();
					if (e.value !== result_value || e.vec !== vector_index
							|| e.comp !== component_index || e.last !== last_result) begin
						$display("%0t: mismatch expected %h v%0d c%0d l%0d actual %h v%0d c%0d l%0d",
							$time, e.value, e.vec, e.comp, e.last, result_value,
							vector_index, component_index, last_result);
						failed = 1'b1;
					end
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic wait_idle();
		while (component_fifo.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_config(logic [3:0] d, logic [3:0] n, logic nrm, bit poke_spare);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_DIMENSION; cfg_data <= d;
		dim_reg = d; fill_pos = 0;
		@(posedge clk);
		cfg_index <= REG_VECTOR_COUNT; cfg_data <= n;
		count_reg = n; fill_pos = 0;
		@(posedge clk);
		cfg_index <= REG_NORMALIZE; cfg_data <= {3'($urandom), nrm};
		norm_reg = nrm;
		if (poke_spare) begin
			@(posedge clk);
			cfg_index <= 2'd3; cfg_data <= 4'($urandom);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] gen_component(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(524288))) - 32'sd262144;
			2: return 32'd0;
			3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $urandom_range(3);
		endcase
	endfunction

	task automatic random_job();
		logic [3:0] d, n;
		int unsigned ed, en, mode;
		logic [31:0] prev[MAXD];
		if ($urandom_range(7) == 0) begin
			d = $urandom_range(15, 8);
			n = $urandom_range(15, 7);
		end else begin
			d = $urandom_range(4);
			n = $urandom_range(4);
		end
		write_config(d, n, $urandom_range(1), $urandom_range(3) == 0);
		ed = eff_dim();
		en = eff_count();
		for (int unsigned v = 0; v < en; v++) begin
			mode = $urandom_range(9);
			for (int unsigned c = 0; c < ed; c++) begin
				if (v > 0 && mode == 9) prev[c] = prev[c];
				else prev[c] = gen_component(mode < 4 ? 0 : mode < 7 ? 1 : mode - 5);
				component_fifo.push_back(prev[c]);
				items_sent++;
			end
		end
		wait_idle();
	endtask

	task automatic directed_job(logic [3:0] d, logic [3:0] n, logic nrm, logic [31:0] vals[$]);
		write_config(d, n, nrm, 1'b1);
		foreach (vals[k]) component_fifo.push_back(vals[k]);
		wait_idle();
	endtask

	initial begin
		int job_no;
		dim_reg = 4'd8;
		count_reg = 4'd8;
		norm_reg = 1'b1;
		fill_pos = 0;
		foreach (vec_mem[v, c]) vec_mem[v][c] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		directed_job(4'd2, 4'd3, 1'b1, '{32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd0,
			32'h7FFFFFFF, 32'h80000000});
		directed_job(4'd3, 4'd2, 1'b0, '{32'd1, 32'd0, 32'd0, 32'h00010000, 32'd2, 32'd0});
		directed_job(4'd1, 4'd1, 1'b1, '{32'd1});
		directed_job(4'd0, 4'd15, 1'b1, '{32'h7FFFFFFF, 32'h80000000, 32'd0, 32'hFFFFFFFF,
			32'h00010000, 32'd1, 32'hFFFF0000, 32'h40000000});
		job_no = 0;
		while (items_sent < 380) begin
			calm = (job_no >= 6 && job_no < 12);
			random_job();
			job_no++;
		end
		calm = 1'b0;
		wait_idle();
		repeat (200) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
